// ===== sv/b2r_pkg.sv =====
`default_nettype none

package b2r_pkg;

    localparam int SymbolCount = 13;
    localparam logic [3:0] SymTop = 4'd12;
    localparam logic [3:0] SymBottom = 4'd0;
    localparam int LengthCap = 64;
    localparam int QueueDepthDefault = 2;

    // register byte addresses
    localparam logic [2:0] AddrMaxLength = 3'd0;
    localparam logic [6:0] MaxLengthReset = 7'd64;

    localparam logic [7:0] CharNul = 8'h00;

    typedef struct packed {
        logic [15:0] value;
        logic [5:0]  lim_m1;   // limit minus one: letters allowed before the cut
    } queue_entry_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    function automatic logic [15:0] sym_weight(input logic [3:0] idx);
        logic [15:0] w;
        unique case (idx)
            4'd0:    w = 16'd1;
            4'd1:    w = 16'd4;
            4'd2:    w = 16'd5;
            4'd3:    w = 16'd9;
            4'd4:    w = 16'd10;
            4'd5:    w = 16'd40;
            4'd6:    w = 16'd50;
            4'd7:    w = 16'd90;
            4'd8:    w = 16'd100;
            4'd9:    w = 16'd400;
            4'd10:   w = 16'd500;
            4'd11:   w = 16'd900;
            4'd12:   w = 16'd1000;
            default: w = 16'd1;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] sym_first(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0, 4'd1, 4'd3:          c = "I";
            4'd2:                      c = "V";
            4'd4, 4'd5, 4'd7:          c = "X";
            4'd6:                      c = "L";
            4'd8, 4'd9, 4'd11:         c = "C";
            4'd10:                     c = "D";
            4'd12:                     c = "M";
            default:                   c = "I";
        endcase
        return c;
    endfunction

    // zero for single-letter symbols
    function automatic logic [7:0] sym_second(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd1:    c = "V";
            4'd3:    c = "X";
            4'd5:    c = "L";
            4'd7:    c = "C";
            4'd9:    c = "D";
            4'd11:   c = "M";
            default: c = CharNul;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/binary_to_roman_encoder.sv =====
`default_nettype none

// channel   dir  payload
// s_axis    in   tdata[15:0] value
// m_axis    out  tdata[7:0] char_code, tuser truncated, tlast last
// apb       in   reg 0 at 0x0: max_length[6:0]
//
// an item is loaded from the queue in the idle state; then each emitted letter and
// each table entry passed over takes a step of the single symbol-compare sequencer,
// which finishes one value before it takes the next one from the queue.
// a queue of queue_depth values lets input run ahead of the sequencer.
// reset is synchronous, active low; the queue empties and max_length reads 64.
// a stalled result holds in the output register and pauses the sequencer.
module binary_to_roman_encoder #(
    parameter int queue_depth = b2r_pkg::QueueDepthDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] char_code
    output logic             m_tuser,   // [0] truncated
    output logic             m_tlast
);

    b2r_pkg::queue_entry_t push_entry;
    b2r_pkg::queue_entry_t head;
    logic                  q_full;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_not_empty;

    assign pready = 1'b1;

    b2r_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_value  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    b2r_queue #(
        .Depth (queue_depth)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (head)
    );

    b2r_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

`ifndef SYNTHESIS
    // the cut flag only rides on the terminator
    a_cut_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("truncated set on a letter transaction");

    // terminator is nul, letters never are
    a_nul_iff_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata == b2r_pkg::CharNul) == m_tlast))
        else $error("nul and last disagree");

    // a full queue never takes a push
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_push)
        else $error("queue overflow");
`endif

endmodule

`default_nettype wire

// ===== sv/b2r_front.sv =====
`default_nettype none

module b2r_front (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_value,
    input  wire logic                  q_full,
    output logic                       q_push,
    output b2r_pkg::queue_entry_t      q_entry
);

    logic [6:0] max_length_reg;
    logic [6:0] max_length_next;

    always_comb begin
        max_length_next = max_length_reg;
        if (psel && penable && pwrite && (paddr == b2r_pkg::AddrMaxLength)) begin
            max_length_next = pwdata[6:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg <= b2r_pkg::MaxLengthReset;
        end else begin
            max_length_reg <= max_length_next;
        end
    end

    assign prdata = (paddr == b2r_pkg::AddrMaxLength) ? {25'd0, max_length_reg} : 32'd0;

    // zero acts as one, anything above the cap acts as the cap
    always_comb begin
        q_entry.value = s_value;
        if (max_length_reg == 7'd0) begin
            q_entry.lim_m1 = 6'd0;
        end else if (max_length_reg > 7'(b2r_pkg::LengthCap)) begin
            q_entry.lim_m1 = 6'(b2r_pkg::LengthCap - 1);
        end else begin
            q_entry.lim_m1 = 6'(max_length_reg - 7'd1);
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

`default_nettype wire

// ===== sv/b2r_queue.sv =====
`default_nettype none

module b2r_queue #(
    parameter int Depth = b2r_pkg::QueueDepthDefault
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire b2r_pkg::queue_entry_t push_entry,
    output logic                       full,
    input  wire logic                  pop,
    output logic                       not_empty,
    output b2r_pkg::queue_entry_t      head
);

    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CountW = $clog2(Depth + 1);

    b2r_pkg::queue_entry_t slot_reg [Depth];
    logic [AddrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AddrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CountW-1:0] count_reg, count_next;

    assign full      = (count_reg == CountW'(Depth));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AddrW'(Depth - 1)) ? '0 : wr_ptr_reg + AddrW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AddrW'(Depth - 1)) ? '0 : rd_ptr_reg + AddrW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CountW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CountW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== sv/b2r_back.sv =====
`default_nettype none

module b2r_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  q_not_empty,
    input  wire b2r_pkg::queue_entry_t q_head,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);

    b2r_pkg::back_state_t state_reg, state_next;

    logic [15:0] rem_reg, rem_next;
    logic [5:0]  pos_reg, pos_next;
    logic [5:0]  lim_m1_reg, lim_m1_next;
    logic [3:0]  idx_reg, idx_next;
    logic        sec_reg, sec_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_char_reg, out_char_next;
    logic        out_cut_reg, out_cut_next;
    logic        out_last_reg, out_last_next;

    logic        adv;
    logic        hit;
    logic        at_limit;
    logic        done;
    logic [15:0] weight;
    logic [7:0]  second;

    assign adv      = !out_valid_reg || m_tready;
    assign weight   = b2r_pkg::sym_weight(idx_reg);
    assign second   = b2r_pkg::sym_second(idx_reg);
    assign hit      = (rem_reg >= weight);
    assign at_limit = (pos_reg == lim_m1_reg);
    // terminator goes out on a cut, or once the lowest symbol no longer fits
    assign done     = adv && ((hit && at_limit) || (!hit && idx_reg == b2r_pkg::SymBottom));

    assign q_pop = (state_reg == b2r_pkg::BK_IDLE) && q_not_empty;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            b2r_pkg::BK_IDLE: begin
                if (q_not_empty) begin
                    state_next = b2r_pkg::BK_RUN;
                end
            end
            b2r_pkg::BK_RUN: begin
                if (done) begin
                    state_next = b2r_pkg::BK_IDLE;
                end
            end
            default: state_next = b2r_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        rem_next       = rem_reg;
        pos_next       = pos_reg;
        lim_m1_next    = lim_m1_reg;
        idx_next       = idx_reg;
        sec_next       = sec_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_cut_next   = out_cut_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            b2r_pkg::BK_IDLE: begin
                if (q_not_empty) begin
                    rem_next    = q_head.value;
                    lim_m1_next = q_head.lim_m1;
                    pos_next    = '0;
                    idx_next    = b2r_pkg::SymTop;
                    sec_next    = 1'b0;
                end
            end
            b2r_pkg::BK_RUN: begin
                if (adv) begin
                    if (done) begin
                        out_valid_next = 1'b1;
                        out_char_next  = b2r_pkg::CharNul;
                        out_cut_next   = hit;
                        out_last_next  = 1'b1;
                    end else if (hit) begin
                        out_valid_next = 1'b1;
                        out_char_next  = sec_reg ? second : b2r_pkg::sym_first(idx_reg);
                        out_cut_next   = 1'b0;
                        out_last_next  = 1'b0;
                        pos_next       = pos_reg + 6'd1;
                        if (second != b2r_pkg::CharNul && !sec_reg) begin
                            sec_next = 1'b1;
                        end else begin
                            sec_next = 1'b0;
                            rem_next = rem_reg - weight;
                        end
                    end else begin
                        idx_next = idx_reg - 4'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= b2r_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg      <= rem_next;
        pos_reg      <= pos_next;
        lim_m1_reg   <= lim_m1_next;
        idx_reg      <= idx_next;
        sec_reg      <= sec_next;
        out_char_reg <= out_char_next;
        out_cut_reg  <= out_cut_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = out_cut_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== sim/binary_to_roman_encoder_test.sv =====
`timescale 1ns / 100ps

module binary_to_roman_encoder_test;

    localparam int CycleLimit = 1000000;
    localparam int HoldCycles = 400;
    localparam int DrainCycles = 100;
    localparam int PhaseCount = 8;
    localparam int PhaseItems = 48;

    // greedy table, lowest weight first
    localparam logic [15:0] NumeralWeight [13] = '{
        16'd1, 16'd4, 16'd5, 16'd9, 16'd10, 16'd40, 16'd50,
        16'd90, 16'd100, 16'd400, 16'd500, 16'd900, 16'd1000
    };
    localparam logic [7:0] NumeralFirst [13] = '{
        "I", "I", "V", "I", "X", "X", "L", "X", "C", "C", "D", "C", "M"
    };
    localparam logic [7:0] NumeralSecond [13] = '{
        8'h00, "V", 8'h00, "X", 8'h00, "L", 8'h00, "C", 8'h00, "D", 8'h00, "M", 8'h00
    };

    typedef struct packed {
        logic [7:0] char_code;
        logic       truncated;
        logic       last;
    } roman_char_t;

    typedef struct {
        logic [15:0] value;
        logic [6:0]  length;
        bit          typed;
        string       text;
        bit          cut;
    } numeral_case_t;

    numeral_case_t numeral_cases [25] = '{
        '{16'd0,     7'd64,  1'b1, "",                1'b0},
        '{16'd1,     7'd64,  1'b1, "I",               1'b0},
        '{16'd4,     7'd64,  1'b1, "IV",              1'b0},
        '{16'd9,     7'd64,  1'b1, "IX",              1'b0},
        '{16'd3999,  7'd64,  1'b1, "MMMCMXCIX",       1'b0},
        '{16'd3888,  7'd64,  1'b1, "MMMDCCCLXXXVIII", 1'b0},
        '{16'd1994,  7'd64,  1'b0, "",                1'b0},
        '{16'd444,   7'd64,  1'b0, "",                1'b0},
        '{16'd949,   7'd64,  1'b0, "",                1'b0},
        '{16'd65535, 7'd64,  1'b0, "",                1'b0},
        '{16'd32768, 7'd64,  1'b0, "",                1'b0},
        '{16'd4,     7'd3,   1'b1, "IV",              1'b0},
        '{16'd7,     7'd3,   1'b1, "VI",              1'b1},
        '{16'd9,     7'd2,   1'b1, "I",               1'b1},
        '{16'd40,    7'd2,   1'b1, "X",               1'b1},
        '{16'd0,     7'd0,   1'b1, "",                1'b0},
        '{16'd5,     7'd0,   1'b1, "",                1'b1},
        '{16'd3999,  7'd1,   1'b1, "",                1'b1},
        '{16'd0,     7'd1,   1'b1, "",                1'b0},
        '{16'd65535, 7'd127, 1'b0, "",                1'b0},
        '{16'd3888,  7'd127, 1'b0, "",                1'b0},
        '{16'd3888,  7'd16,  1'b1, "MMMDCCCLXXXVIII", 1'b0},
        '{16'd3888,  7'd15,  1'b0, "",                1'b0},
        '{16'd65535, 7'd100, 1'b0, "",                1'b0},
        '{16'd2024,  7'd64,  1'b0, "",                1'b0}
    };

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;     // [15:0] value
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;     // [7:0] char_code
    logic        m_tuser;     // [0] truncated
    logic        m_tlast;

    roman_char_t roman_expect [$];
    int          cur_length = b2r_pkg::MaxLengthReset;
    int          burst_left = 0;
    bit          hold_request = 1'b0;
    int          holds_done = 0;
    int          errors = 0;
    int          values_sent = 0;
    int          letters_seen = 0;
    int          cuts_seen = 0;
    int          cycle_count = 0;

    binary_to_roman_encoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // expected characters of one conversion at the current length setting
    task automatic predict_numeral(input logic [15:0] value);
        int  budget;
        int  emitted;
        int  rest;
        bit  cut;
        budget = (cur_length == 0) ? 0 : ((cur_length > 64) ? 63 : cur_length - 1);
        rest = value;
        emitted = 0;
        cut = 1'b0;
        for (int idx = 12; idx >= 0; idx--) begin
            while (!cut && rest >= NumeralWeight[idx]) begin
                if (emitted == budget) begin
                    cut = 1'b1;
                end else begin
                    roman_expect.push_back('{NumeralFirst[idx], 1'b0, 1'b0});
                    emitted++;
                    if (NumeralSecond[idx] != b2r_pkg::CharNul) begin
                        if (emitted == budget) begin
                            cut = 1'b1;
                        end else begin
                            roman_expect.push_back('{NumeralSecond[idx], 1'b0, 1'b0});
                            emitted++;
                        end
                    end
                    if (!cut) begin
                        rest -= NumeralWeight[idx];
                    end
                end
            end
        end
        roman_expect.push_back('{b2r_pkg::CharNul, cut, 1'b1});
    endtask

    // entered and left just after a falling edge
    task automatic send_value(input logic [15:0] value, input bit typed,
                              input string text, input bit cut);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        if (typed) begin
            for (int k = 0; k < text.len(); k++) begin
                roman_expect.push_back('{text[k], 1'b0, 1'b0});
            end
            roman_expect.push_back('{b2r_pkg::CharNul, cut, 1'b1});
        end else begin
            predict_numeral(value);
        end
        values_sent++;
        @(negedge aclk);
    endtask

    // sender pauses until every pending character is out, then reprograms the length
    task automatic set_length(input logic [6:0] len);
        s_tvalid <= 1'b0;
        while (roman_expect.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= b2r_pkg::AddrMaxLength;
        pwdata  <= {25'd0, len};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_length = len;
        burst_left = 0;
    endtask

    function automatic logic [15:0] random_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) return 16'($urandom_range(0, 20));
        if (pick < 70) return 16'($urandom_range(1, 3999));
        if (pick < 85) return 16'($urandom_range(3000, 3999));
        return 16'($urandom_range(0, 65535));
    endfunction

    initial begin
        logic [6:0] len;
        aresetn = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (numeral_cases[i]) begin
            if (numeral_cases[i].length != cur_length) begin
                set_length(numeral_cases[i].length);
            end
            send_value(numeral_cases[i].value, numeral_cases[i].typed,
                       numeral_cases[i].text, numeral_cases[i].cut);
        end

        for (int p = 0; p < PhaseCount; p++) begin
            unique case (p)
                0: len = 7'd64;
                1: len = 7'd16;
                2: len = 7'd1;
                3: len = 7'd127;
                4: len = 7'd0;
                5: len = 7'd5;
                6: len = 7'($urandom_range(2, 63));
                default: len = 7'($urandom_range(65, 126));
            endcase
            set_length(len);
            // long receiver stall while the input keeps coming
            if (p == 3) begin
                hold_request = 1'b1;
            end
            for (int n = 0; n < PhaseItems; n++) begin
                send_value(random_value(), 1'b0, "", 1'b0);
            end
        end

        s_tvalid <= 1'b0;
        while (roman_expect.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
        $display("%0d conversions over lengths 0 to 127, %0d letters checked,",
                 values_sent, letters_seen);
        $display("%0d cut terminators, %0d long output stalls", cuts_seen, holds_done);
        if (errors == 0) begin
            $display("binary_to_roman_encoder_test OK");
        end else begin
            $display("binary_to_roman_encoder_test NOT OK");
        end
        $finish;
    end

    // receiver stall pattern, with its period and stall re-chosen at random
    initial begin
        int period;
        int stall;
        int left;
        int phase;
        m_tready = 1'b0;
        period = 1;
        stall = 0;
        left = 0;
        phase = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HoldCycles) @(negedge aclk);
                hold_request = 1'b0;
                holds_done++;
            end
            if (left == 0) begin
                left = 50;
                period = $urandom_range(1, 8);
                stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, period - 1);
            end
            left--;
            phase++;
            m_tready <= ((phase % period) >= stall);
        end
    end

    always @(posedge aclk) begin
        roman_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (roman_expect.size() == 0) begin
                errors++;
                $display("%0t: expected no transaction, actual char %h truncated %b last %b",
                         $time, m_tdata, m_tuser, m_tlast);
            end else begin
                want = roman_expect.pop_front();
                if (m_tdata !== want.char_code) begin
                    errors++;
                    $display("%0t: char_code expected %h actual %h",
                             $time, want.char_code, m_tdata);
                end
                if (m_tuser !== want.truncated) begin
                    errors++;
                    $display("%0t: truncated expected %b actual %b",
                             $time, want.truncated, m_tuser);
                end
                if (m_tlast !== want.last) begin
                    errors++;
                    $display("%0t: last expected %b actual %b", $time, want.last, m_tlast);
                end
                if (!want.last) letters_seen++;
                if (want.truncated) cuts_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("%0t: timeout with %0d characters still expected",
                     $time, roman_expect.size());
            $display("binary_to_roman_encoder_test NOT OK");
            $finish;
        end
    end

endmodule
